[hdl/dsa_pkg.sv]
package dsa_pkg;

  localparam int MaxEntries = 9;

  localparam int OpW   = 2;
  localparam int TimeW = 11;
  localparam int IdxW  = 4;
  localparam int RotW  = 4;
  localparam int PtrW  = 4;
  localparam int MinW  = 6;
  localparam int CntW  = 10;
  localparam int UpcW  = 3;

  localparam logic [OpW-1:0] OpClock    = 2'd0;
  localparam logic [OpW-1:0] OpWrite    = 2'd1;
  localparam logic [OpW-1:0] OpFindNext = 2'd2;
  localparam logic [OpW-1:0] OpConflict = 2'd3;

  localparam logic CfgFeedingMode = 1'b0;
  localparam logic CfgEntryCount  = 1'b1;

  localparam logic [TimeW-1:0] MinPerHour  = 11'd60;
  localparam logic [TimeW-1:0] ConflictWin = 11'd5;
  // A raw distance at or above this folds to five minutes or less over the day.
  localparam logic [TimeW-1:0] ConflictFar = 11'd1435;
  localparam logic [CntW-1:0]  CounterTop  = 10'd999;
  localparam logic [MinW-1:0]  NoMinute    = 6'd63;
  // floor(t * Recip60 / 2^16) is t/60 or one less for any 11-bit t.
  localparam logic [TimeW-1:0] Recip60     = 11'd1092;

  // Microprogram addresses
  localparam logic [UpcW-1:0] UcDisp    = 3'd0;
  localparam logic [UpcW-1:0] UcClkMul  = 3'd1;
  localparam logic [UpcW-1:0] UcClkFire = 3'd2;
  localparam logic [UpcW-1:0] UcWrite   = 3'd3;
  localparam logic [UpcW-1:0] UcFnFirst = 3'd4;
  localparam logic [UpcW-1:0] UcFnLoop  = 3'd5;
  localparam logic [UpcW-1:0] UcCfLoop  = 3'd6;
  localparam logic [UpcW-1:0] UcEmit    = 3'd7;

  typedef enum logic [2:0] {
    ActDisp,
    ActMulQ,
    ActFire,
    ActWrite,
    ActFnFirst,
    ActFnStep,
    ActCfStep,
    ActEmit
  } act_e;

  typedef enum logic [2:0] {
    JmpNext,
    JmpOpcode,
    JmpAlways,
    JmpWhile,
    JmpEmit
  } jmp_e;

  typedef struct packed {
    act_e            act;
    jmp_e            jmp;
    logic [UpcW-1:0] tgt;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UpcW-1:0] addr);
    ucode_t w;
    unique case (addr)
      UcDisp:    w = '{act: ActDisp,    jmp: JmpOpcode, tgt: UcDisp};
      UcClkMul:  w = '{act: ActMulQ,    jmp: JmpNext,   tgt: UcClkFire};
      UcClkFire: w = '{act: ActFire,    jmp: JmpAlways, tgt: UcEmit};
      UcWrite:   w = '{act: ActWrite,   jmp: JmpAlways, tgt: UcEmit};
      UcFnFirst: w = '{act: ActFnFirst, jmp: JmpNext,   tgt: UcFnLoop};
      UcFnLoop:  w = '{act: ActFnStep,  jmp: JmpWhile,  tgt: UcEmit};
      UcCfLoop:  w = '{act: ActCfStep,  jmp: JmpWhile,  tgt: UcEmit};
      UcEmit:    w = '{act: ActEmit,    jmp: JmpEmit,   tgt: UcDisp};
      default:   w = '{act: ActEmit,    jmp: JmpEmit,   tgt: UcDisp};
    endcase
    return w;
  endfunction

  function automatic logic [UpcW-1:0] dispatch_tgt(input logic [OpW-1:0] op);
    logic [UpcW-1:0] t;
    unique case (op)
      OpClock:    t = UcClkMul;
      OpWrite:    t = UcWrite;
      OpFindNext: t = UcFnFirst;
      OpConflict: t = UcCfLoop;
      default:    t = UcEmit;
    endcase
    return t;
  endfunction

endpackage

[hdl/daily_schedule_alarm.sv]
// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_stall_o  opcode, time_minutes, entry_index, rotations
// out       source     out_valid_o / out_stall_i alarm_fired, fired_rotations, next_entry,
//                                               conflict, auto_fire_count
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request at a time runs through a microprogram of one control word per cycle.
// Control words per request: clock sample dispatch, multiply, fire, emit; write entry
// dispatch, write, emit; find next dispatch, first entry, scan loop, emit; conflict
// check dispatch, scan loop, emit; the scan over up to MAX_ENTRIES entries is longest.
// The result register lets the next request be taken while a result waits on stall.
// Reset clears the table, pointer, counter, last minute (63) and both config registers;
// there is no clearing pass.
module daily_schedule_alarm #(
  parameter int MAX_ENTRIES = dsa_pkg::MaxEntries
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dsa_pkg::OpW-1:0]    opcode_i,
  input  logic [dsa_pkg::TimeW-1:0]  time_minutes_i,
  input  logic [dsa_pkg::IdxW-1:0]   entry_index_i,
  input  logic [dsa_pkg::RotW-1:0]   rotations_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       alarm_fired_o,
  output logic [dsa_pkg::RotW-1:0]   fired_rotations_o,
  output logic [dsa_pkg::PtrW-1:0]   next_entry_o,
  output logic                       conflict_o,
  output logic [dsa_pkg::CntW-1:0]   auto_fire_count_o,
  // configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [3:0]                 cfg_data_i
);

  // Address width of the table, and width of a scan index that can hold the count.
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = dsa_pkg::TimeW + dsa_pkg::RotW;

  // Control state
  logic                       busy_q;
  logic [dsa_pkg::UpcW-1:0]   upc_q, upc_d;
  logic                       out_valid_q;

  // Architectural state
  logic [EW-1:0]              table_q [MAX_ENTRIES];
  logic [dsa_pkg::PtrW-1:0]   ptr_q;
  logic [dsa_pkg::MinW-1:0]   last_min_q;
  logic [dsa_pkg::CntW-1:0]   fire_cnt_q;
  logic                       mode_q;
  logic [3:0]                 ecount_q;

  // Datapath registers
  logic [CW-1:0]              addr_q;
  logic [dsa_pkg::TimeW-1:0]  prev_q;
  logic                       fired_q;
  logic [dsa_pkg::RotW-1:0]   frot_q;
  logic                       conf_q;

  // Request and result payload (no reset)
  logic [dsa_pkg::OpW-1:0]    op_q;
  logic [dsa_pkg::TimeW-1:0]  t_q;
  logic [dsa_pkg::IdxW-1:0]   idx_q;
  logic [dsa_pkg::RotW-1:0]   rot_q;
  logic [21:0]                prod_q;
  logic                       o_fired_q;
  logic [dsa_pkg::RotW-1:0]   o_frot_q;
  logic [dsa_pkg::PtrW-1:0]   o_next_q;
  logic                       o_conf_q;
  logic [dsa_pkg::CntW-1:0]   o_cnt_q;

  dsa_pkg::ucode_t            uc;
  logic                       in_acc;
  logic                       can_emit;
  logic [4:0]                 cnt_w;
  logic [CW-1:0]              cnt;
  logic                       more;
  logic                       addr_ok;
  logic [EW-1:0]              rd_entry;
  logic [dsa_pkg::TimeW-1:0]  rd_time;
  logic [dsa_pkg::RotW-1:0]   rd_rot;
  logic [5:0]                 quot;
  logic [dsa_pkg::TimeW-1:0]  rem_raw;
  logic [dsa_pkg::MinW-1:0]   minute;
  logic                       fire_hit;
  logic [dsa_pkg::TimeW-1:0]  tdiff;
  logic                       conf_hit;
  logic                       wr_ok;

  assign uc          = dsa_pkg::ucode_rom(upc_q);
  assign in_stall_o  = busy_q;
  assign in_acc      = in_valid_i && !busy_q;
  assign cfg_ready_o = 1'b1;
  assign can_emit    = !out_valid_q || !out_stall_i;

  // Entries in use: clamp the programmed count to the table depth.
  assign cnt_w = ({1'b0, ecount_q} > 5'(MAX_ENTRIES)) ? 5'(MAX_ENTRIES) : {1'b0, ecount_q};
  assign cnt   = cnt_w[CW-1:0];
  assign more  = addr_q < cnt;

  // Single read port on the table, addressed by the scan index.
  assign addr_ok  = {{(6-CW){1'b0}}, addr_q} < 6'(MAX_ENTRIES);
  assign rd_entry = addr_ok ? table_q[addr_q[AW-1:0]] : '0;
  assign rd_time  = rd_entry[dsa_pkg::TimeW-1:0];
  assign rd_rot   = rd_entry[EW-1:dsa_pkg::TimeW];

  // Minute of hour: quotient estimate is exact or one short, so one fix-up subtract.
  assign quot    = prod_q[21:16];
  assign rem_raw = t_q - (11'(quot) * dsa_pkg::MinPerHour);
  assign minute  = (rem_raw >= dsa_pkg::MinPerHour) ? 6'(rem_raw - dsa_pkg::MinPerHour)
                                                    : 6'(rem_raw);

  // Fire when the pointer lies inside the entries in use and its time matches.
  assign fire_hit = (cnt_w != 5'd0) && ({1'b0, ptr_q} < cnt_w) && (rd_time == t_q);

  // Circular distance within five minutes, folded over the day (raw values).
  assign tdiff    = (rd_time >= t_q) ? (rd_time - t_q) : (t_q - rd_time);
  assign conf_hit = (tdiff <= dsa_pkg::ConflictWin) || (tdiff >= dsa_pkg::ConflictFar);

  assign wr_ok = {1'b0, idx_q} < 5'(MAX_ENTRIES);

  // Next microprogram address
  always_comb begin
    upc_d = upc_q + dsa_pkg::UpcW'(1);
    unique case (uc.jmp)
      dsa_pkg::JmpNext:   upc_d = upc_q + dsa_pkg::UpcW'(1);
      dsa_pkg::JmpOpcode: upc_d = dsa_pkg::dispatch_tgt(op_q);
      dsa_pkg::JmpAlways: upc_d = uc.tgt;
      dsa_pkg::JmpWhile:  upc_d = more ? upc_q : uc.tgt;
      dsa_pkg::JmpEmit:   upc_d = can_emit ? uc.tgt : upc_q;
      default:            upc_d = uc.tgt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= dsa_pkg::UcDisp;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      last_min_q  <= dsa_pkg::NoMinute;
      fire_cnt_q  <= '0;
      mode_q      <= 1'b0;
      ecount_q    <= '0;
      addr_q      <= '0;
      prev_q      <= '0;
      fired_q     <= 1'b0;
      frot_q      <= '0;
      conf_q      <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        table_q[i] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          dsa_pkg::CfgFeedingMode: mode_q   <= cfg_data_i[0];
          dsa_pkg::CfgEntryCount:  ecount_q <= cfg_data_i;
          default:                 mode_q   <= mode_q;
        endcase
      end

      // drop a delivered result, unless the emit step loads the next one on this edge
      if (out_valid_q && !out_stall_i && !(busy_q && uc.act == dsa_pkg::ActEmit)) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        busy_q <= 1'b1;
        upc_q  <= dsa_pkg::UcDisp;
      end else if (busy_q) begin
        upc_q <= upc_d;
        unique case (uc.act)
          dsa_pkg::ActDisp: begin
            fired_q <= 1'b0;
            frot_q  <= '0;
            conf_q  <= 1'b0;
            addr_q  <= (op_q == dsa_pkg::OpClock) ? CW'(ptr_q) : '0;
          end
          dsa_pkg::ActMulQ: begin
            addr_q <= addr_q;
          end
          dsa_pkg::ActFire: begin
            if (minute != last_min_q && !mode_q) begin
              last_min_q <= minute;
              if (fire_hit) begin
                fired_q    <= 1'b1;
                frot_q     <= rd_rot;
                fire_cnt_q <= (fire_cnt_q >= dsa_pkg::CounterTop) ? 10'd1
                                                                  : fire_cnt_q + 10'd1;
                ptr_q      <= ({1'b0, ptr_q} >= cnt_w - 5'd1) ? '0
                                                              : ptr_q + 4'd1;
              end
            end
          end
          dsa_pkg::ActWrite: begin
            if (wr_ok) begin
              table_q[idx_q[AW-1:0]] <= {rot_q, t_q};
            end
          end
          dsa_pkg::ActFnFirst: begin
            ptr_q  <= '0;
            prev_q <= rd_time;
            addr_q <= CW'(1);
          end
          dsa_pkg::ActFnStep: begin
            if (more) begin
              if (t_q > prev_q && t_q <= rd_time) begin
                ptr_q <= 4'(addr_q);
              end
              prev_q <= rd_time;
              addr_q <= addr_q + CW'(1);
            end
          end
          dsa_pkg::ActCfStep: begin
            if (more) begin
              conf_q <= conf_q | conf_hit;
              addr_q <= addr_q + CW'(1);
            end
          end
          dsa_pkg::ActEmit: begin
            if (can_emit) begin
              out_valid_q <= 1'b1;
              busy_q      <= 1'b0;
            end
          end
          default: begin
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

  // Request capture, multiply stage and result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      t_q   <= time_minutes_i;
      idx_q <= entry_index_i;
      rot_q <= rotations_i;
    end
    if (busy_q && uc.act == dsa_pkg::ActMulQ) begin
      prod_q <= 22'(t_q) * 22'(dsa_pkg::Recip60);
    end
    if (busy_q && uc.act == dsa_pkg::ActEmit && can_emit) begin
      o_fired_q <= fired_q;
      o_frot_q  <= frot_q;
      o_next_q  <= ptr_q;
      o_conf_q  <= conf_q;
      o_cnt_q   <= fire_cnt_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign alarm_fired_o     = o_fired_q;
  assign fired_rotations_o = o_frot_q;
  assign next_entry_o      = o_next_q;
  assign conflict_o        = o_conf_q;
  assign auto_fire_count_o = o_cnt_q;

  // Assertions
  a_idle_at_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> upc_q == dsa_pkg::UcDisp)
    else $error("sequencer idle away from dispatch");

  a_ptr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ptr_q} < 5'(MAX_ENTRIES))
    else $error("next pointer beyond table");

  a_counter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_cnt_q <= dsa_pkg::CounterTop)
    else $error("fire counter out of range");

  a_fire_xor_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(alarm_fired_o && conflict_o))
    else $error("alarm and conflict in one result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && upc_q == dsa_pkg::UcDisp)
    else $error("accepted request did not start the program");

endmodule

[bench/daily_schedule_alarm_tb.sv]
module daily_schedule_alarm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DayMinutes = 1440;
  localparam int HalfDay    = 720;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int PrintCap   = 60;

  // One result of the block, field for field.
  typedef struct packed {
    logic                     fired;
    logic [dsa_pkg::RotW-1:0] rot;
    logic [dsa_pkg::PtrW-1:0] nxt;
    logic                     conf;
    logic [dsa_pkg::CntW-1:0] total;
  } alarm_res_t;

  localparam alarm_res_t NoRes     = '0;
  localparam alarm_res_t FirstFire = '{fired: 1'b1, rot: 4'd9, nxt: 4'd1, conf: 1'b0,
                                       total: 10'd1};

  // One directed request plus the config it runs under.
  typedef struct packed {
    logic                      mode;
    logic [3:0]                count;
    logic [dsa_pkg::OpW-1:0]   op;
    logic [dsa_pkg::TimeW-1:0] t;
    logic [dsa_pkg::IdxW-1:0]  idx;
    logic [dsa_pkg::RotW-1:0]  rot;
    logic                      typed;
    alarm_res_t                want;
  } drill_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [dsa_pkg::OpW-1:0]    opcode_i;
  logic [dsa_pkg::TimeW-1:0]  time_minutes_i;
  logic [dsa_pkg::IdxW-1:0]   entry_index_i;
  logic [dsa_pkg::RotW-1:0]   rotations_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic                       alarm_fired_o;
  logic [dsa_pkg::RotW-1:0]   fired_rotations_o;
  logic [dsa_pkg::PtrW-1:0]   next_entry_o;
  logic                       conflict_o;
  logic [dsa_pkg::CntW-1:0]   auto_fire_count_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic                       cfg_index_i;
  logic [3:0]                 cfg_data_i;

  // Mirror of the schedule state, updated at every accepted request.
  logic [dsa_pkg::TimeW-1:0]  sched_time [dsa_pkg::MaxEntries];
  logic [dsa_pkg::RotW-1:0]   sched_rot  [dsa_pkg::MaxEntries];
  logic [dsa_pkg::PtrW-1:0]   cur_ptr;
  logic [dsa_pkg::MinW-1:0]   seen_minute;
  logic [dsa_pkg::CntW-1:0]   fire_total;
  logic                       manual_mode;
  logic [3:0]                 slots_cfg;
  bit                         counter_wrapped;

  alarm_res_t        due_results [$];
  drill_row_t        drill_rows [23];
  int                mismatches;
  int                cycles;
  int                gap_pct;
  int                stall_pct;
  bit                calm;
  bit                hold_req;

  daily_schedule_alarm u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .time_minutes_i    (time_minutes_i),
    .entry_index_i     (entry_index_i),
    .rotations_i       (rotations_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .alarm_fired_o     (alarm_fired_o),
    .fired_rotations_o (fired_rotations_o),
    .next_entry_o      (next_entry_o),
    .conflict_o        (conflict_o),
    .auto_fire_count_o (auto_fire_count_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Entries in use: a count above the table size means the whole table.
  function automatic int slots_live();
    return (slots_cfg > dsa_pkg::MaxEntries) ? dsa_pkg::MaxEntries : int'(slots_cfg);
  endfunction

  // Advance the schedule mirror by one request and return what the block must report.
  function automatic alarm_res_t schedule_step(input logic [dsa_pkg::OpW-1:0] op,
                                               input logic [dsa_pkg::TimeW-1:0] t,
                                               input logic [dsa_pkg::IdxW-1:0] idx,
                                               input logic [dsa_pkg::RotW-1:0] rot);
    alarm_res_t res;
    int live;
    int minute;
    int d;
    res  = NoRes;
    live = slots_live();
    case (op)
      dsa_pkg::OpClock: begin
        minute = int'(t) % int'(dsa_pkg::MinPerHour);
        // Same minute as last time, or manual mode: nothing happens, last minute kept.
        if (minute != int'(seen_minute) && !manual_mode) begin
          if (live > 0 && int'(cur_ptr) < live && sched_time[cur_ptr] == t) begin
            res.fired = 1'b1;
            res.rot   = sched_rot[cur_ptr];
            if (fire_total >= dsa_pkg::CounterTop) begin
              fire_total      = 10'd1;
              counter_wrapped = 1'b1;
            end else begin
              fire_total = fire_total + 1'b1;
            end
            // Wrap the pointer once it sits on or past the last live entry.
            cur_ptr = (int'(cur_ptr) >= live - 1) ? '0 : cur_ptr + 1'b1;
          end
          seen_minute = dsa_pkg::MinW'(minute);
        end
      end
      dsa_pkg::OpWrite: begin
        // Slots past the table are dropped.
        if (idx < dsa_pkg::MaxEntries) begin
          sched_time[idx] = t;
          sched_rot[idx]  = rot;
        end
      end
      dsa_pkg::OpFindNext: begin
        cur_ptr = '0;
        for (int i = 1; i < live; i++) begin
          if (t > sched_time[i-1] && t <= sched_time[i]) cur_ptr = dsa_pkg::PtrW'(i);
        end
      end
      default: begin
        // Circular distance on raw values; a fold past the day may go negative.
        for (int i = 0; i < live && !res.conf; i++) begin
          d = int'(sched_time[i]) - int'(t);
          if (d < 0) d = -d;
          if (d > HalfDay) d = DayMinutes - d;
          if (d <= int'(dsa_pkg::ConflictWin)) res.conf = 1'b1;
        end
      end
    endcase
    res.nxt   = cur_ptr;
    res.total = fire_total;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want_v);
    if (mismatches < PrintCap) begin
      $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want_v);
    end
    mismatches++;
  endtask

  // Offer one request, hold it through stall, and log its expected result on accept.
  task automatic push_request(input logic [dsa_pkg::OpW-1:0] op,
                              input logic [dsa_pkg::TimeW-1:0] t,
                              input logic [dsa_pkg::IdxW-1:0] idx,
                              input logic [dsa_pkg::RotW-1:0] rot,
                              input logic typed, input alarm_res_t typed_res);
    alarm_res_t res;
    if (!hold_req && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    time_minutes_i <= t;
    entry_index_i  <= idx;
    rotations_i    <= rot;
    do @(posedge clk_i); while (in_stall_o);
    res = schedule_step(op, t, idx, rot);
    due_results.push_back(typed ? typed_res : res);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back; call only with the block idle.
  task automatic write_config(input logic mode, input logic [3:0] count);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= dsa_pkg::CfgFeedingMode;
    cfg_data_i  <= {3'b000, mode};
    do @(posedge clk_i); while (!cfg_ready_o);
    manual_mode = mode;
    cfg_index_i <= dsa_pkg::CfgEntryCount;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    slots_cfg = count;
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase: config, optionally a fresh sorted table, then a mix of clock
  // samples aimed at the entry under the pointer and random noise requests.
  task automatic run_phase(input logic mode, input logic [3:0] count, input int n,
                           input bit fresh, input int aim_pct, input bit stop_on_wrap);
    int t;
    int live;
    int k;
    logic [dsa_pkg::TimeW-1:0] tgt;
    logic [dsa_pkg::OpW-1:0] op;
    drain_results();
    write_config(mode, count);
    if (fresh) begin
      t = $urandom_range(0, 100);
      for (int i = 0; i < dsa_pkg::MaxEntries; i++) begin
        push_request(dsa_pkg::OpWrite, dsa_pkg::TimeW'(t), dsa_pkg::IdxW'(i),
                     dsa_pkg::RotW'($urandom_range(0, 15)), 1'b0, NoRes);
        t = t + $urandom_range(1, 170);
        if (t > DayMinutes - 1) t = DayMinutes - 1;
      end
      push_request(dsa_pkg::OpFindNext, dsa_pkg::TimeW'($urandom_range(0, DayMinutes - 1)),
                   '0, '0, 1'b0, NoRes);
    end
    for (int j = 0; j < n; j++) begin
      if (stop_on_wrap && counter_wrapped) break;
      // Re-roll idle rates now and then so gaps land everywhere, zero included.
      if (!calm && j % 100 == 0) begin
        gap_pct   = $urandom_range(0, 3) * 8;
        stall_pct = $urandom_range(0, 3) * 8;
      end
      live = slots_live();
      if ($urandom_range(0, 99) < aim_pct) begin
        if (live == 0 || int'(cur_ptr) >= live) begin
          // Pointer parked past the live entries: pull it back with a search.
          push_request(dsa_pkg::OpFindNext,
                       dsa_pkg::TimeW'($urandom_range(0, DayMinutes - 1)),
                       dsa_pkg::IdxW'($urandom_range(0, 15)),
                       dsa_pkg::RotW'($urandom_range(0, 15)), 1'b0, NoRes);
        end else begin
          tgt = sched_time[cur_ptr];
          // Same minute as the last sample would be ignored: step the minute first.
          if (int'(tgt) % int'(dsa_pkg::MinPerHour) == int'(seen_minute)) tgt = tgt + 1'b1;
          push_request(dsa_pkg::OpClock, tgt, dsa_pkg::IdxW'($urandom_range(0, 15)),
                       dsa_pkg::RotW'($urandom_range(0, 15)), 1'b0, NoRes);
        end
      end else begin
        op = dsa_pkg::OpW'($urandom_range(0, 3));
        k  = $urandom_range(0, dsa_pkg::MaxEntries - 1);
        case ($urandom_range(0, 3))
          0:       t = $urandom_range(0, 2047);
          1:       t = $urandom_range(0, DayMinutes - 1);
          default: t = int'(sched_time[k]) + $urandom_range(0, 14) - 7;
        endcase
        push_request(op, dsa_pkg::TimeW'(t), dsa_pkg::IdxW'($urandom_range(0, 15)),
                     dsa_pkg::RotW'($urandom_range(0, 15)), 1'b0, NoRes);
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off when asked for.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare every accepted result against the oldest outstanding one.
  always @(posedge clk_i) begin : watch_results
    alarm_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", auto_fire_count_o, 0);
      end else begin
        want = due_results.pop_front();
        if (alarm_fired_o !== want.fired)
          report_mismatch("alarm_fired", alarm_fired_o, want.fired);
        if (fired_rotations_o !== want.rot)
          report_mismatch("fired_rotations", fired_rotations_o, want.rot);
        if (next_entry_o !== want.nxt)
          report_mismatch("next_entry", next_entry_o, want.nxt);
        if (conflict_o !== want.conf)
          report_mismatch("conflict", conflict_o, want.conf);
        if (auto_fire_count_o !== want.total)
          report_mismatch("auto_fire_count", auto_fire_count_o, want.total);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("daily_schedule_alarm_tb: errors");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = '0;
    time_minutes_i = '0;
    entry_index_i  = '0;
    rotations_i    = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = 1'b0;
    cfg_data_i     = '0;
    mismatches     = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    for (int i = 0; i < dsa_pkg::MaxEntries; i++) begin
      sched_time[i] = '0;
      sched_rot[i]  = '0;
    end
    cur_ptr         = '0;
    seen_minute     = dsa_pkg::NoMinute;
    fire_total      = '0;
    manual_mode     = 1'b0;
    slots_cfg       = '0;
    counter_wrapped = 1'b0;

    // Directed rows: mode, count, op, time, slot, rotations, typed, expected.
    drill_rows = '{
      // Fresh from reset, no entries in use: nothing fires, nothing conflicts.
      '{0, 0,  dsa_pkg::OpClock,    1439, 0,  0,  1, NoRes},
      '{0, 0,  dsa_pkg::OpConflict, 0,    0,  0,  1, NoRes},
      '{0, 0,  dsa_pkg::OpFindNext, 1439, 0,  0,  1, NoRes},
      // Table fill; slots nine and fifteen are past the table and dropped.
      '{0, 0,  dsa_pkg::OpWrite,    0,    0,  9,  1, NoRes},
      '{0, 0,  dsa_pkg::OpWrite,    1439, 8,  15, 1, NoRes},
      '{0, 0,  dsa_pkg::OpWrite,    2047, 15, 15, 1, NoRes},
      '{0, 0,  dsa_pkg::OpWrite,    100,  9,  5,  1, NoRes},
      '{0, 0,  dsa_pkg::OpWrite,    5,    1,  1,  1, NoRes},
      '{0, 0,  dsa_pkg::OpWrite,    720,  2,  2,  1, NoRes},
      // Count of fifteen clamps to the full table; midnight entry fires first.
      '{0, 15, dsa_pkg::OpClock,    0,    0,  0,  1, FirstFire},
      '{0, 15, dsa_pkg::OpClock,    5,    0,  0,  0, NoRes},
      '{0, 15, dsa_pkg::OpClock,    660,  0,  0,  0, NoRes},
      // Matches the entry but repeats the minute just seen: suppressed.
      '{0, 15, dsa_pkg::OpClock,    720,  0,  0,  0, NoRes},
      '{0, 15, dsa_pkg::OpClock,    721,  0,  0,  0, NoRes},
      '{0, 15, dsa_pkg::OpClock,    720,  0,  0,  0, NoRes},
      // Conflicts across midnight and from a time past the day.
      '{0, 15, dsa_pkg::OpConflict, 1437, 0,  0,  0, NoRes},
      '{0, 15, dsa_pkg::OpConflict, 2047, 0,  0,  0, NoRes},
      '{0, 15, dsa_pkg::OpConflict, 300,  0,  0,  0, NoRes},
      '{0, 15, dsa_pkg::OpFindNext, 3,    0,  0,  0, NoRes},
      // Manual mode holds off a matching sample.
      '{1, 9,  dsa_pkg::OpClock,    1439, 0,  0,  0, NoRes},
      // Pointer left past a shrunken count never fires.
      '{0, 2,  dsa_pkg::OpClock,    1439, 0,  0,  0, NoRes},
      '{0, 2,  dsa_pkg::OpFindNext, 4,    0,  0,  0, NoRes},
      // Fire on the last live entry and wrap the pointer to zero.
      '{0, 2,  dsa_pkg::OpClock,    5,    0,  0,  0, NoRes}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (drill_rows[r]) begin
      if (drill_rows[r].mode != manual_mode || drill_rows[r].count != slots_cfg) begin
        drain_results();
        write_config(drill_rows[r].mode, drill_rows[r].count);
      end
      push_request(drill_rows[r].op, drill_rows[r].t, drill_rows[r].idx, drill_rows[r].rot,
                   drill_rows[r].typed, drill_rows[r].want);
    end

    // Mostly aimed samples until the fire counter has wrapped past 999.
    run_phase(1'b0, 4'd9, 1300, 1'b1, 95, 1'b1);
    run_phase(1'b1, 4'd9, 40, 1'b0, 60, 1'b0);
    run_phase(1'b0, 4'd0, 40, 1'b1, 60, 1'b0);

    // Back-pressure: the receiver holds off while requests keep coming.
    hold_req = 1'b1;
    run_phase(1'b0, 4'd15, 60, 1'b1, 70, 1'b0);

    run_phase(1'b0, 4'd10, 50, 1'b0, 60, 1'b0);
    run_phase(1'b0, 4'd1, 40, 1'b1, 60, 1'b0);
    run_phase(1'b0, 4'($urandom_range(2, 8)), 50, 1'b1, 60, 1'b0);
    run_phase(1'b1, 4'd0, 20, 1'b0, 50, 1'b0);

    // Closing stretch at full rate on both sides.
    calm      = 1'b1;
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(1'b0, 4'd9, 80, 1'b1, 70, 1'b0);

    drain_results();
    repeat (24) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("daily_schedule_alarm_tb: clean");
    end else begin
      $display("daily_schedule_alarm_tb: errors");
    end
    $finish;
  end

endmodule

[daily_schedule_alarm.f]
hdl/dsa_pkg.sv
hdl/daily_schedule_alarm.sv
bench/daily_schedule_alarm_tb.sv
